// File: design/sfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_pkg: shared types, constants and helpers for substring first match
// character width, config register codes and case-folded compare
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int TEXT_MAX_DEF    = 65536;
    localparam int CHAR_BITS_DEF   = 16;

    // fixed field widths of the ports
    localparam int FIELD_W   = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_REG_W = 4;

    // ascii letter bounds
    localparam logic [FIELD_W-1:0] ASCII_UPPER_A = 16'h0041;
    localparam logic [FIELD_W-1:0] ASCII_UPPER_Z = 16'h005a;
    localparam logic [FIELD_W-1:0] ASCII_LOWER_A = 16'h0061;
    localparam logic [FIELD_W-1:0] ASCII_LOWER_Z = 16'h007a;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2,
        CFG_IGNORE_CASE  = 2'd3
    } t_cfg_idx;

    // control handed from the top level to every cell
    typedef struct packed {
        logic shift;
        logic ignore_case;
    } t_cell_ctrl;

    function automatic logic [FIELD_W-1:0] fold_char(input logic [FIELD_W-1:0] c);
        logic [FIELD_W-1:0] res;
        res = c;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            res = c - ASCII_UPPER_A + ASCII_LOWER_A;
        end
        return res;
    endfunction

    function automatic logic chars_equal(input logic [FIELD_W-1:0] a,
                                         input logic [FIELD_W-1:0] b,
                                         input logic               fold);
        logic eq;
        if (fold) begin
            eq = (fold_char(a) == fold_char(b));
        end else begin
            eq = (a == b);
        end
        return eq;
    endfunction

endpackage
`default_nettype wire

// File: design/sfm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfm_cell: one window cell
// holds one earlier character, passes it on, compares it with its pattern char
// ----------------------------------------------------------------------------
module sfm_cell #(
    parameter int PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF,
    parameter int CHAR_BITS   = sfm_pkg::CHAR_BITS_DEF,
    parameter int CELL_IDX    = 0,
    localparam int LEN_W      = $clog2(PATTERN_MAX + 1),
    localparam int IDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  wire                                  i_clk,
    input  wire sfm_pkg::t_cell_ctrl             i_ctrl,
    input  wire [CHAR_BITS-1:0]                  i_char,
    input  wire [PATTERN_MAX-1:0][CHAR_BITS-1:0] i_pattern,
    input  wire [LEN_W-1:0]                      i_len,
    output logic [CHAR_BITS-1:0]                 o_char,
    output logic                                 o_hit
);

    // cell k lines up with pattern char len-2-k; unused when len < k+2
    localparam logic [LEN_W-1:0] NEED = LEN_W'(CELL_IDX + 2);

    logic [CHAR_BITS-1:0] r_char;
    logic [IDX_W-1:0]     w_sel;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_char <= i_char;
        end
    end

    always_comb begin
        w_sel = IDX_W'(i_len - NEED);
        o_hit = 1'b1;
        if (i_len >= NEED) begin
            o_hit = sfm_pkg::chars_equal(sfm_pkg::FIELD_W'(r_char),
                                         sfm_pkg::FIELD_W'(i_pattern[w_sel]),
                                         i_ctrl.ignore_case);
        end
    end

    assign o_char = r_char;

endmodule
`default_nettype wire

// File: design/substring_first_match_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// substring_first_match_top: streaming first-occurrence substring search
// compares a window of recent characters with a pattern of up to eight chars
// ----------------------------------------------------------------------------
// usage
//   input channel: one text character per transfer, last_char marks the end
//   of a text. output channel: one transfer per text, sent after its final
//   character, with found, the start index of the first match and overflow.
//   config port: write pattern words, length and case folding while idle.
// throughput
//   one character per cycle while input ready holds (see stall). the result
//   is registered as the final character is taken. the compare window is a
//   row of PATTERN_MAX-1 cells that shift on each input transfer within the
//   text limit and all compare in the same cycle, so it never limits rate.
// reset
//   clears config to zero pattern, length one, exact compare, and clears the
//   stream counters and the pending result
// stall
//   while a result waits and the receiver holds off, a new character is still
//   taken unless it would produce a second result; then input ready drops
// ----------------------------------------------------------------------------
module substring_first_match_top #(
    parameter int PATTERN_MAX = sfm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = sfm_pkg::TEXT_MAX_DEF,
    parameter int CHAR_BITS   = sfm_pkg::CHAR_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input channel
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire [sfm_pkg::FIELD_W-1:0]     i_text_char,
    input  wire                            i_last_char,
    // output channel
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_found,
    output logic [sfm_pkg::FIELD_W-1:0]    o_match_index,
    output logic                           o_overflow,
    // config port
    input  wire                            i_cfg_wr_en,
    input  wire [sfm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [sfm_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int POS_W = $clog2(TEXT_MAX + 1);
    localparam int FW    = sfm_pkg::FIELD_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(TEXT_MAX);

    // config registers
    logic [sfm_pkg::CFG_W-1:0]     r_pat_low;
    logic [sfm_pkg::CFG_W-1:0]     r_pat_high;
    logic [sfm_pkg::LEN_REG_W-1:0] r_pat_len;
    logic                          r_ignore_case;

    // stream state
    logic [POS_W-1:0] r_pos,         n_pos;
    logic             r_match_seen,  n_match_seen;
    logic [FW-1:0]    r_first_start, n_first_start;
    logic             r_exceeded,    n_exceeded;

    // result register
    logic          r_out_valid;
    logic          r_found;
    logic [FW-1:0] r_match_index;
    logic          r_overflow;

    logic                                  w_in_xfer;
    logic                                  w_in_range;
    logic                                  w_enough;
    logic                                  w_hit_now;
    logic [LEN_W-1:0]                      w_len;
    logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] w_pattern;
    logic [PATTERN_MAX-1:0]                w_hit;
    logic [CHAR_BITS-1:0]                  w_link [PATTERN_MAX];
    logic [POS_W:0]                        w_start;
    sfm_pkg::t_cell_ctrl                   w_ctrl;

    // ---------------- config port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low     <= '0;
            r_pat_high    <= '0;
            r_pat_len     <= sfm_pkg::LEN_REG_W'(1);
            r_ignore_case <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (sfm_pkg::t_cfg_idx'(i_cfg_index))
                sfm_pkg::CFG_PATTERN_LOW:  r_pat_low     <= i_cfg_data;
                sfm_pkg::CFG_PATTERN_HIGH: r_pat_high    <= i_cfg_data;
                sfm_pkg::CFG_PATTERN_LEN:  r_pat_len     <= i_cfg_data[sfm_pkg::LEN_REG_W-1:0];
                sfm_pkg::CFG_IGNORE_CASE:  r_ignore_case <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective length: zero acts as one, large values clip to the window
    always_comb begin
        priority if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > sfm_pkg::LEN_REG_W'(PATTERN_MAX)) begin
            w_len = LEN_W'(PATTERN_MAX);
        end else begin
            w_len = LEN_W'(r_pat_len);
        end
    end

    // unpack pattern chars, four per config word
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k < 4) begin
                w_pattern[k] = r_pat_low[k*FW +: CHAR_BITS];
            end else begin
                w_pattern[k] = r_pat_high[(k-4)*FW +: CHAR_BITS];
            end
        end
    end

    // ---------------- handshake ----------------
    // a new final character needs the result register free (or leaving)
    assign o_in_ready = !r_out_valid || i_out_ready || !i_last_char;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_in_range    = (r_pos < POS_LIMIT);
    assign w_ctrl.shift       = w_in_xfer && w_in_range;
    assign w_ctrl.ignore_case = r_ignore_case;

    // ---------------- cell row ----------------
    // link 0 is the arriving char; cell k holds the char k+1 places back
    assign w_link[0] = i_text_char[CHAR_BITS-1:0];

    // the arriving char lines up with the last pattern char
    assign w_hit[PATTERN_MAX-1] = sfm_pkg::chars_equal(
        FW'(i_text_char[CHAR_BITS-1:0]),
        FW'(w_pattern[IDX_W'(w_len - LEN_W'(1))]),
        r_ignore_case);

    for (genvar g = 0; g < PATTERN_MAX - 1; g++) begin : g_cell
        sfm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .CHAR_BITS   (CHAR_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_char    (w_link[g]),
            .i_pattern (w_pattern),
            .i_len     (w_len),
            .o_char    (w_link[g+1]),
            .o_hit     (w_hit[g])
        );
    end

    // ---------------- match tracking ----------------
    // enough chars seen once pos+1 >= len
    assign w_enough  = ((POS_W+1)'(r_pos) + (POS_W+1)'(1)) >= (POS_W+1)'(w_len);
    assign w_hit_now = w_in_range && !r_match_seen && w_enough && (&w_hit);
    assign w_start   = (POS_W+1)'(r_pos) + (POS_W+1)'(1) - (POS_W+1)'(w_len);

    always_comb begin
        n_pos         = w_in_range ? r_pos + POS_W'(1) : r_pos;
        n_match_seen  = r_match_seen || w_hit_now;
        n_first_start = w_hit_now ? FW'(w_start) : r_first_start;
        n_exceeded    = r_exceeded || !w_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_match_seen  <= 1'b0;
            r_first_start <= '0;
            r_exceeded    <= 1'b0;
        end else if (w_in_xfer) begin
            if (i_last_char) begin
                // end of text: back to a clean stream
                r_pos         <= '0;
                r_match_seen  <= 1'b0;
                r_first_start <= '0;
                r_exceeded    <= 1'b0;
            end else begin
                r_pos         <= n_pos;
                r_match_seen  <= n_match_seen;
                r_first_start <= n_first_start;
                r_exceeded    <= n_exceeded;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && i_last_char) begin
            r_found       <= n_match_seen;
            r_match_index <= n_match_seen ? n_first_start : '0;
            r_overflow    <= n_exceeded;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;
    assign o_overflow    = r_overflow;

    // ---------------- assertions ----------------
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last_char) |=> o_out_valid)
        else $error("final char transfer did not raise a result");

    a_index_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_index == '0))
        else $error("match index nonzero without a match");

    a_stream_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_last_char) |=> (r_pos == '0 && !r_match_seen && !r_exceeded))
        else $error("stream state not cleared after final char");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("position ran past the text limit");

    a_match_drops_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_match_seen) |-> ($past(w_in_xfer && i_last_char) || $past(!i_rst_n)))
        else $error("match flag dropped inside a text");

endmodule
`default_nettype wire
